// ----- rtl/dnd_pkg.sv -----
// types, constants and calendar tables for the date next-day / weekday pipeline
// used by dnd_calendar, dnd_ordinal and date_next_day_and_weekday
package dnd_pkg;

  localparam int BaseYearInt = 1900;

  localparam logic [11:0] BASE_YEAR = 12'(BaseYearInt);
  localparam logic [12:0] LAST_YEAR = 13'd4095;

  // leap years in 1 .. BASE_YEAR-1
  localparam int LeapsBase = (BaseYearInt - 1) / 4 - (BaseYearInt - 1) / 100
                             + (BaseYearInt - 1) / 400;
  // absolute day number of the day before BASE_YEAR-01-01, mod 7
  localparam int OriginMod7 = (365 * (BaseYearInt - 1) + LeapsBase) % 7;

  localparam logic [10:0] LEAPS_BASE   = 11'(LeapsBase);
  localparam logic [5:0]  ORIGIN_MOD7  = 6'(OriginMod7);
  localparam logic [12:0] RECIP100     = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;

  typedef struct packed {
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [11:0] in_year;
  } dnd_in_req_t;

  typedef struct packed {
    logic        date_valid;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [12:0] next_year;
    logic [19:0] day_ordinal;
    logic [2:0]  next_weekday;
  } dnd_out_res_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } dnd_stage_en_t;

  typedef struct packed {
    logic        date_ok;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  mlen;
    logic [8:0]  doy_base;
    logic [19:0] days365;
    logic [10:0] leaps_rel;
  } dnd_cal_t;

  function automatic logic [4:0] dnd_month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] dnd_days_before(input logic [3:0] m);
    logic [8:0] db;
    case (m)
      4'd1:    db = 9'd0;
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

// ----- rtl/date_next_day_and_weekday.sv -----
// top level of the date next-day / weekday pipeline: handshake and stage valids
// depends on dnd_pkg, dnd_calendar, dnd_ordinal
//
//   channel   ports                          payload
//   input     in_valid, in_ready, in_req     dnd_in_req_t (day, month, year)
//   result    out_valid, out_ready, out_res  dnd_out_res_t
//
// one request per cycle sustained while the output is not stalled; a result is
// offered once its request has passed the four register stages
// each stage advances when it is empty or the stage after it advances,
// so bubbles close up and a stalled output holds every stage behind it
// rst_n (synchronous) clears the stage valids only
module date_next_day_and_weekday import dnd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  dnd_in_req_t  in_req,
  output logic         out_valid,
  input  logic         out_ready,
  output dnd_out_res_t out_res
);

  logic [3:0]    vld_r, vld_nxt;
  logic [3:0]    adv;
  dnd_stage_en_t en_cal, en_ord;
  dnd_cal_t      cal;

  always_comb begin
    adv[3]  = !vld_r[3] || out_ready;
    adv[2]  = !vld_r[2] || adv[3];
    adv[1]  = !vld_r[1] || adv[2];
    adv[0]  = !vld_r[0] || adv[1];
    vld_nxt = vld_r;
    if (adv[0]) vld_nxt[0] = in_valid;
    if (adv[1]) vld_nxt[1] = vld_r[0];
    if (adv[2]) vld_nxt[2] = vld_r[1];
    if (adv[3]) vld_nxt[3] = vld_r[2];
    en_cal.load_a = adv[0];
    en_cal.load_b = adv[1];
    en_ord.load_a = adv[2];
    en_ord.load_b = adv[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dnd_calendar u_calendar (
    .clk (clk),
    .en  (en_cal),
    .req (in_req),
    .cal (cal)
  );

  dnd_ordinal u_ordinal (
    .clk (clk),
    .en  (en_ord),
    .cal (cal),
    .res (out_res)
  );

  assign in_ready  = adv[0];
  assign out_valid = vld_r[3];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request did not enter first stage");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.date_valid |-> (out_res.day_ordinal == 20'd0)
      && (out_res.next_day == 5'd0) && (out_res.next_year == 13'd0))
    else $error("invalid date gave nonzero result");

  a_valid_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.date_valid |-> (out_res.next_weekday <= 3'd6)
      && (out_res.day_ordinal != 20'd0) && (out_res.next_day != 5'd0)
      && (out_res.next_month >= MONTH_JAN) && (out_res.next_month <= MONTH_DEC))
    else $error("valid date gave out-of-range result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !out_ready |=> vld_r[3] && $stable(out_res))
    else $error("stalled result changed");

endmodule

// ----- rtl/dnd_calendar.sv -----
// first two pipeline stages: range check, year/100 by reciprocal, leap rule,
// month length, day-of-year base and whole-year day counts
// depends on dnd_pkg
module dnd_calendar import dnd_pkg::*; (
  input  logic          clk,
  input  dnd_stage_en_t en,
  input  dnd_in_req_t   req,
  output dnd_cal_t      cal
);

  // stage 1
  logic [4:0]  day1_r, day1_nxt;
  logic [3:0]  month1_r, month1_nxt;
  logic [11:0] year1_r, year1_nxt;
  logic [24:0] prod1_r, prod1_nxt;
  logic [19:0] days365_1_r, days365_1_nxt;
  logic        range_ok1_r, range_ok1_nxt;
  logic [11:0] ym1;
  logic [11:0] dy;

  // stage 2
  dnd_cal_t    cal2_r, cal2_nxt;
  logic [5:0]  q100;
  logic [5:0]  q100_inc;
  logic [11:0] rem100;
  logic        century;
  logic        leap;
  logic [4:0]  mlen;

  function automatic logic [9:0] ym1_quarter(input logic [11:0] y);
    logic [11:0] ym;
    ym = y - 12'd1;
    return ym[11:2];
  endfunction

  always_comb begin
    ym1           = req.in_year - 12'd1;
    dy            = req.in_year - BASE_YEAR;
    day1_nxt      = req.in_day;
    month1_nxt    = req.in_month;
    year1_nxt     = req.in_year;
    prod1_nxt     = {13'd0, ym1} * {12'd0, RECIP100};
    days365_1_nxt = {8'd0, dy} * 20'd365;
    range_ok1_nxt = (req.in_month >= MONTH_JAN) && (req.in_month <= MONTH_DEC)
                    && (req.in_year >= BASE_YEAR) && ({1'b0, req.in_year} <= LAST_YEAR)
                    && (req.in_day != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      day1_r      <= day1_nxt;
      month1_r    <= month1_nxt;
      year1_r     <= year1_nxt;
      prod1_r     <= prod1_nxt;
      days365_1_r <= days365_1_nxt;
      range_ok1_r <= range_ok1_nxt;
    end
  end

  // q100 is (year-1)/100; year is a century exactly when (year-1) mod 100 is 99
  always_comb begin
    q100     = prod1_r[RECIP_SHIFT +: 6];
    q100_inc = q100 + 6'd1;
    rem100   = (year1_r - 12'd1) - ({6'd0, q100} * 12'd100);
    century  = (rem100 == 12'd99);
    leap     = (year1_r[1:0] == 2'b00) && (!century || (q100_inc[1:0] == 2'b00));
    mlen     = dnd_month_days(month1_r, leap);

    cal2_nxt.date_ok   = range_ok1_r && (day1_r <= mlen);
    cal2_nxt.day       = day1_r;
    cal2_nxt.month     = month1_r;
    cal2_nxt.year      = year1_r;
    cal2_nxt.mlen      = mlen;
    cal2_nxt.doy_base  = dnd_days_before(month1_r)
                         + {8'd0, (month1_r > MONTH_FEB) && leap};
    cal2_nxt.days365   = days365_1_r;
    cal2_nxt.leaps_rel = {1'b0, ym1_quarter(year1_r)} - {5'd0, q100}
                         + {7'd0, q100[5:2]} - LEAPS_BASE;
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      cal2_r <= cal2_nxt;
    end
  end

  assign cal = cal2_r;

endmodule

// ----- rtl/dnd_ordinal.sv -----
// last two pipeline stages: ordinal day sum and following date,
// then weekday by folding the ordinal mod 7 and zeroing invalid dates
// depends on dnd_pkg
module dnd_ordinal import dnd_pkg::*; (
  input  logic          clk,
  input  dnd_stage_en_t en,
  input  dnd_cal_t      cal,
  output dnd_out_res_t  res
);

  // stage 3
  logic        ok3_r, ok3_nxt;
  logic [19:0] ord3_r, ord3_nxt;
  logic [4:0]  nday3_r, nday3_nxt;
  logic [3:0]  nmonth3_r, nmonth3_nxt;
  logic [12:0] nyear3_r, nyear3_nxt;
  logic        last_day;

  // stage 4
  dnd_out_res_t res4_r, res4_nxt;
  logic [5:0]   grp_sum;
  logic [3:0]   fold;
  logic [2:0]   wday;

  always_comb begin
    last_day    = (cal.day == cal.mlen);
    ok3_nxt     = cal.date_ok;
    ord3_nxt    = cal.days365 + {9'd0, cal.leaps_rel} + {11'd0, cal.doy_base}
                  + {15'd0, cal.day};
    nday3_nxt   = last_day ? 5'd1 : cal.day + 5'd1;
    nmonth3_nxt = cal.month;
    nyear3_nxt  = {1'b0, cal.year};
    if (last_day) begin
      if (cal.month == MONTH_DEC) begin
        nmonth3_nxt = MONTH_JAN;
        nyear3_nxt  = {1'b0, cal.year} + 13'd1;
      end else begin
        nmonth3_nxt = cal.month + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      ok3_r     <= ok3_nxt;
      ord3_r    <= ord3_nxt;
      nday3_r   <= nday3_nxt;
      nmonth3_r <= nmonth3_nxt;
      nyear3_r  <= nyear3_nxt;
    end
  end

  // 8 is 1 mod 7, so 3-bit groups add up to the same residue
  always_comb begin
    grp_sum = {3'd0, ord3_r[2:0]} + {3'd0, ord3_r[5:3]} + {3'd0, ord3_r[8:6]}
              + {3'd0, ord3_r[11:9]} + {3'd0, ord3_r[14:12]} + {3'd0, ord3_r[17:15]}
              + {4'd0, ord3_r[19:18]} + ORIGIN_MOD7;
    fold    = {1'b0, grp_sum[5:3]} + {1'b0, grp_sum[2:0]};
    wday    = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];

    res4_nxt = '0;
    if (ok3_r) begin
      res4_nxt.date_valid   = 1'b1;
      res4_nxt.next_day     = nday3_r;
      res4_nxt.next_month   = nmonth3_r;
      res4_nxt.next_year    = nyear3_r;
      res4_nxt.day_ordinal  = ord3_r;
      res4_nxt.next_weekday = wday;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      res4_r <= res4_nxt;
    end
  end

  assign res = res4_r;

endmodule

// ----- dv/date_result_checker.sv -----
// result checker for date_next_day_and_weekday: predicts each result from the accepted request
// and compares it field by field with what the block returns
// depends on dnd_pkg
module date_result_checker import dnd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  dnd_in_req_t  in_req,
  input  logic         out_valid,
  input  logic         out_ready,
  input  dnd_out_res_t out_res,
  output int           mismatch_count,
  output int           pending_count,
  output int           valid_dates,
  output int           rejected_dates,
  output int           year_rollovers
);
  timeunit 1ns;
  timeprecision 1ps;

  dnd_out_res_t expected_q[$];
  int errors = 0;
  int n_valid = 0;
  int n_rejected = 0;
  int n_rollover = 0;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      4, 6, 9, 11: return 30;
      MONTH_FEB:   return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // days counted from 0001-01-01 as 1
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned doy;
    int unsigned py;
    doy = d;
    for (int unsigned k = 1; k < m; k++) begin
      doy += month_length(k, leap_year(y));
    end
    py = y - 1;
    return 365 * py + py / 4 - py / 100 + py / 400 + doy;
  endfunction

  function automatic dnd_out_res_t predict_next_date(input dnd_in_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    int unsigned here;
    int unsigned origin;
    dnd_out_res_t res;
    d = r.in_day;
    m = r.in_month;
    y = r.in_year;
    res = '0;
    if (m < MONTH_JAN || m > MONTH_DEC || y < BASE_YEAR || y > LAST_YEAR || d < 1) begin
      return res;
    end
    len = month_length(m, leap_year(y));
    if (d > len) begin
      return res;
    end
    here   = day_number(y, m, d);
    origin = day_number(int'(BASE_YEAR) - 1, MONTH_DEC, 31);
    res.date_valid = 1'b1;
    if (d == len) begin
      res.next_day = 5'd1;
      if (m == MONTH_DEC) begin
        res.next_month = MONTH_JAN;
        res.next_year  = 13'(y + 1);
      end else begin
        res.next_month = 4'(m + 1);
        res.next_year  = 13'(y);
      end
    end else begin
      res.next_day   = 5'(d + 1);
      res.next_month = 4'(m);
      res.next_year  = 13'(y);
    end
    res.day_ordinal  = 20'(here - origin);
    res.next_weekday = 3'(here % 7);
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    dnd_out_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result returned with no request pending");
          errors++;
        end else begin
          want = expected_q.pop_front();
          compare_field("date_valid", want.date_valid, out_res.date_valid);
          compare_field("next_day", want.next_day, out_res.next_day);
          compare_field("next_month", want.next_month, out_res.next_month);
          compare_field("next_year", want.next_year, out_res.next_year);
          compare_field("day_ordinal", want.day_ordinal, out_res.day_ordinal);
          compare_field("next_weekday", want.next_weekday, out_res.next_weekday);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_next_date(in_req);
        expected_q.push_back(want);
        if (want.date_valid) begin
          n_valid++;
          if (want.next_year != 13'(in_req.in_year)) begin
            n_rollover++;
          end
        end else begin
          n_rejected++;
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_q.size();
    valid_dates    <= n_valid;
    rejected_dates <= n_rejected;
    year_rollovers <= n_rollover;
  end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for date_next_day_and_weekday: clock, reset, date requests, output stalls
// and the verdict; checking is done by date_result_checker
// depends on dnd_pkg, date_result_checker and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dnd_pkg::*;

  localparam int ResetCycles   = 11;
  localparam int QuietLimit    = 5000;
  localparam int HoldOffCycles = 300;
  localparam int DatesPerPhase = 520;
  localparam int DrainCycles   = 8;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  dnd_in_req_t  in_req;
  logic         out_valid;
  logic         out_ready;
  dnd_out_res_t out_res;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_wanted = 0;
  int stalls_served = 0;

  int mismatch_count;
  int pending_count;
  int valid_dates;
  int rejected_dates;
  int year_rollovers;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  date_next_day_and_weekday dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  date_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (out_res),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .valid_dates    (valid_dates),
    .rejected_dates (rejected_dates),
    .year_rollovers (year_rollovers)
  );

  function automatic dnd_in_req_t make_date(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    dnd_in_req_t r;
    r.in_day   = d[4:0];
    r.in_month = m[3:0];
    r.in_year  = y[11:0];
    return r;
  endfunction

  // mostly plausible dates, with month ends, leap and century years and range edges
  function automatic dnd_in_req_t random_date();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
    case ($urandom_range(0, 5))
      0:       y = $urandom_range(1900, 4095);
      1:       y = 4 * $urandom_range(475, 1023);
      2:       y = 100 * $urandom_range(19, 40);
      3:       y = $urandom_range(4090, 4095);
      4:       y = $urandom_range(1900, 1905);
      default: y = $urandom_range(1950, 2100);
    endcase
    case ($urandom_range(0, 11))
      0: begin
        d = $urandom;
        m = $urandom;
        y = $urandom;
      end
      1:       y = $urandom_range(0, 1899);
      2:       m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
      default: ;
    endcase
    return make_date(d, m, y);
  endfunction

  task automatic send_date(input dnd_in_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // result side: random stalls, plus a long hold-off on demand
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served < stalls_wanted) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        stalls_served++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("date_next_day_and_weekday verification failed");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    send_date(make_date(1, 1, 1900));
    send_date(make_date(31, 12, 1899));
    send_date(make_date(31, 12, 1900));
    send_date(make_date(1, 1, 4095));
    send_date(make_date(31, 12, 4095));
    send_date(make_date(29, 2, 2000));
    send_date(make_date(29, 2, 1900));
    send_date(make_date(29, 2, 2100));
    send_date(make_date(29, 2, 2400));
    send_date(make_date(29, 2, 2004));
    send_date(make_date(29, 2, 2003));
    send_date(make_date(28, 2, 2003));
    send_date(make_date(28, 2, 2004));
    send_date(make_date(1, 3, 2004));
    send_date(make_date(30, 4, 2021));
    send_date(make_date(31, 4, 2021));
    send_date(make_date(31, 1, 2021));
    send_date(make_date(0, 6, 2021));
    send_date(make_date(15, 0, 2021));
    send_date(make_date(15, 13, 2021));
    send_date(make_date(31, 15, 4095));
    send_date(make_date(0, 0, 0));
    send_date(make_date(31, 12, 1999));
    send_date(make_date(31, 12, 2047));
    send_date(make_date(30, 11, 3000));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stalls_wanted++;
        end
      endcase
      repeat (DatesPerPhase) send_date(random_date());
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d dates requested: %0d valid (%0d rolling into a new year), %0d rejected",
             valid_dates + rejected_dates, valid_dates, year_rollovers, rejected_dates);
    $display("idling mixes 18/61, 61/18 and none, plus one %0d-cycle output hold-off",
             HoldOffCycles);
    if (mismatch_count == 0) begin
      $display("date_next_day_and_weekday verification clean");
    end else begin
      $display("date_next_day_and_weekday verification failed");
    end
    $finish;
  end

endmodule
